// ===== hdl/i2crm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crm_pkg
// Item types and fixed codes shared by the I2C register master files.
// ----------------------------------------------------------------------------
package i2crm_pkg;

  // command codes carried in the tick item
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_RECOVER = 3'd1;
  localparam logic [2:0] CMD_WRITE   = 3'd2;
  localparam logic [2:0] CMD_READ8   = 3'd3;
  localparam logic [2:0] CMD_READ16  = 3'd4;
  localparam logic [2:0] CMD_BURST   = 3'd5;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_TICKS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESTART_GAP = 1'b1;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [9:0]  PHASE_TICKS_RST = 10'd10;
  localparam logic [11:0] RESTART_GAP_RST = 12'd50;

  typedef struct packed {
    logic [2:0] cmd;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] burst_len;
    logic       sda_in;
  } tick_item_t;

  typedef struct packed {
    logic        scl_drive_low;
    logic        sda_drive_low;
    logic        busy_res;
    logic        read_valid;
    logic [15:0] read_value;
    logic        last_read;
  } res_item_t;

endpackage

// ===== hdl/i2crm_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crm_seq
// Bus sequencer: latches a command, steps the phase machine once per tick
// and forms the pin drives and read data of that tick.
// ----------------------------------------------------------------------------
module i2crm_seq import i2crm_pkg::*; #(
  parameter int unsigned RECOVERY_PULSES = 9
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  tick_item_t  tick_item,
  input  logic [9:0]  phase_ticks,
  input  logic [11:0] restart_gap_ticks,
  output res_item_t   result
);

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_REC_HIGH   = 4'd1,
    PH_REC_LOW    = 4'd2,
    PH_START_IDLE = 4'd3,
    PH_START_HOLD = 4'd4,
    PH_TX_LOW     = 4'd5,
    PH_TX_HIGH    = 4'd6,
    PH_GAP        = 4'd7,
    PH_RX_LOW     = 4'd8,
    PH_RX_HIGH    = 4'd9,
    PH_ACK_LOW    = 4'd10,
    PH_ACK_HIGH   = 4'd11,
    PH_STOP_LOW   = 4'd12,
    PH_STOP_HIGH  = 4'd13,
    PH_STOP_DONE  = 4'd14
  } phase_t;

  // which byte of the frame is on the wire
  localparam logic [1:0] TX_ADDR = 2'd0;
  localparam logic [1:0] TX_REG  = 2'd1;
  localparam logic [1:0] TX_DATA = 2'd2;
  localparam logic [1:0] TX_READ = 2'd3;

  phase_t      phase, phase_next, phase_e;
  logic [2:0]  active_cmd, cmd_next, cmd_e;
  logic [11:0] tick_count, tick_next, tick_e;
  logic [3:0]  bit_count, bit_next, bit_e;
  logic [7:0]  shift_byte, shift_next;
  logic [7:0]  bytes_left, left_next, left_e, left_dec;
  logic [7:0]  low_hold, hold_next, hold_e;
  logic [6:0]  dev_addr, dev_next;
  logic [7:0]  reg_addr, reg_next;
  logic [7:0]  wr_data, wr_next;
  logic [1:0]  tx_stage, tx_next, tx_e;
  logic        start, ack;
  logic [11:0] len;
  logic [12:0] tick_inc;
  logic [3:0]  bit_inc;

  always_comb begin
    start = (phase == PH_IDLE) &&
            (tick_item.cmd == CMD_RECOVER || tick_item.cmd == CMD_WRITE ||
             tick_item.cmd == CMD_READ8 || tick_item.cmd == CMD_READ16 ||
             tick_item.cmd == CMD_BURST);

    // state as seen at the start of this tick, after a new command is latched
    phase_e  = phase;
    cmd_e    = active_cmd;
    tick_e   = tick_count;
    bit_e    = bit_count;
    left_e   = bytes_left;
    hold_e   = low_hold;
    tx_e     = tx_stage;
    dev_next = dev_addr;
    reg_next = reg_addr;
    wr_next  = wr_data;
    if (start) begin
      dev_next = tick_item.dev_addr;
      reg_next = tick_item.reg_addr;
      wr_next  = tick_item.write_data;
      cmd_e    = tick_item.cmd;
      tx_e     = TX_ADDR;
      hold_e   = 8'd0;
      tick_e   = 12'd0;
      case (tick_item.cmd)
        CMD_READ8:  left_e = 8'd1;
        CMD_READ16: left_e = 8'd2;
        default:    left_e = tick_item.burst_len;
      endcase
      if (tick_item.cmd == CMD_RECOVER) begin
        bit_e   = 4'(RECOVERY_PULSES - 1);
        phase_e = PH_REC_HIGH;
      end else begin
        phase_e = PH_START_IDLE;
      end
    end

    ack = (left_e > 8'd1);

    // pin drives of the current phase
    result = '0;
    result.busy_res = (phase_e != PH_IDLE);
    case (phase_e)
      PH_REC_LOW, PH_GAP, PH_RX_LOW: result.scl_drive_low = 1'b1;
      PH_START_HOLD, PH_STOP_HIGH:   result.sda_drive_low = 1'b1;
      PH_STOP_LOW: begin
        result.scl_drive_low = 1'b1;
        result.sda_drive_low = 1'b1;
      end
      PH_TX_LOW, PH_TX_HIGH: begin
        result.scl_drive_low = (phase_e == PH_TX_LOW);
        result.sda_drive_low = (bit_e < 4'd8) && !shift_byte[7];
      end
      PH_ACK_LOW: begin
        result.scl_drive_low = 1'b1;
        result.sda_drive_low = ack;
      end
      PH_ACK_HIGH: result.sda_drive_low = ack;
      default: ;
    endcase

    phase_next = phase_e;
    cmd_next   = cmd_e;
    tick_next  = tick_e;
    bit_next   = bit_e;
    shift_next = shift_byte;
    left_next  = left_e;
    hold_next  = hold_e;
    tx_next    = tx_e;

    len      = (phase_e == PH_GAP) ? restart_gap_ticks
             : (phase_ticks == 10'd0) ? 12'd1 : {2'b00, phase_ticks};
    tick_inc = {1'b0, tick_e} + 13'd1;
    bit_inc  = bit_e + 4'd1;
    left_dec = (left_e != 8'd0) ? left_e - 8'd1 : 8'd0;

    if (phase_e != PH_IDLE) begin
      if (tick_inc < {1'b0, len}) begin
        tick_next = tick_inc[11:0];
      end else begin
        tick_next = 12'd0;
        case (phase_e)
          PH_REC_HIGH: phase_next = PH_REC_LOW;
          PH_REC_LOW: begin
            if (bit_e == 4'd0) begin
              phase_next = PH_STOP_LOW;
            end else begin
              bit_next   = bit_e - 4'd1;
              phase_next = PH_REC_HIGH;
            end
          end
          PH_START_IDLE: phase_next = PH_START_HOLD;
          PH_START_HOLD: begin
            shift_next = {dev_next, tx_e == TX_READ};
            bit_next   = 4'd0;
            phase_next = PH_TX_LOW;
          end
          PH_TX_LOW: phase_next = PH_TX_HIGH;
          PH_TX_HIGH: begin
            if (bit_e < 4'd8) begin
              shift_next = {shift_byte[6:0], 1'b0};
            end
            bit_next = bit_inc;
            if (bit_inc < 4'd9) begin
              phase_next = PH_TX_LOW;
            end else if (tx_e == TX_ADDR) begin
              tx_next    = TX_REG;
              shift_next = reg_next;
              bit_next   = 4'd0;
              phase_next = PH_TX_LOW;
            end else if (tx_e == TX_REG) begin
              if (cmd_e == CMD_WRITE) begin
                tx_next    = TX_DATA;
                shift_next = wr_next;
                bit_next   = 4'd0;
                phase_next = PH_TX_LOW;
              end else begin
                tx_next = TX_READ;
                // a zero gap goes straight to the repeated start
                phase_next = (restart_gap_ticks == 12'd0) ? PH_START_IDLE : PH_GAP;
              end
            end else if (tx_e == TX_READ && left_e != 8'd0) begin
              bit_next   = 4'd0;
              shift_next = 8'd0;
              phase_next = PH_RX_LOW;
            end else begin
              phase_next = PH_STOP_LOW;
            end
          end
          PH_GAP:    phase_next = PH_START_IDLE;
          PH_RX_LOW: phase_next = PH_RX_HIGH;
          PH_RX_HIGH: begin
            shift_next = {shift_byte[6:0], tick_item.sda_in};
            bit_next   = bit_inc;
            phase_next = (bit_inc >= 4'd8) ? PH_ACK_LOW : PH_RX_LOW;
          end
          PH_ACK_LOW: phase_next = PH_ACK_HIGH;
          PH_ACK_HIGH: begin
            if (cmd_e == CMD_READ16 && left_e > 8'd1) begin
              hold_next = shift_byte;
            end else begin
              result.read_valid = 1'b1;
              result.last_read  = (left_e <= 8'd1);
              result.read_value = (cmd_e == CMD_READ16) ? {shift_byte, hold_e}
                                                        : {8'd0, shift_byte};
            end
            left_next = left_dec;
            if (left_dec == 8'd0) begin
              phase_next = PH_STOP_LOW;
            end else begin
              bit_next   = 4'd0;
              shift_next = 8'd0;
              phase_next = PH_RX_LOW;
            end
          end
          PH_STOP_LOW:  phase_next = PH_STOP_HIGH;
          PH_STOP_HIGH: phase_next = PH_STOP_DONE;
          default:      phase_next = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      active_cmd <= 3'd0;
      tick_count <= 12'd0;
      bit_count  <= 4'd0;
      shift_byte <= 8'd0;
      bytes_left <= 8'd0;
      low_hold   <= 8'd0;
      dev_addr   <= 7'd0;
      reg_addr   <= 8'd0;
      wr_data    <= 8'd0;
      tx_stage   <= TX_ADDR;
    end else if (step) begin
      phase      <= phase_next;
      active_cmd <= cmd_next;
      tick_count <= tick_next;
      bit_count  <= bit_next;
      shift_byte <= shift_next;
      bytes_left <= left_next;
      low_hold   <= hold_next;
      dev_addr   <= dev_next;
      reg_addr   <= reg_next;
      wr_data    <= wr_next;
      tx_stage   <= tx_next;
    end
  end

endmodule

// ===== hdl/i2c_register_master_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_master_core
// Open-drain I2C register master stepped once per tick item, with a result
// register and a skid stage on the output side.
// ----------------------------------------------------------------------------
//  channel   signals                                 direction  item
//  tick      tick_valid, tick_stall, tick_item       in         one timing tick
//  result    res_valid, res_stall, res_item          out        pin drives, data
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  in      register write
//
//  one tick item taken per clock while tick_stall is low; result is registered
//  the sequencer state register closes the phase machine loop
//  tick_stall rises only when the skid stage holds a result (output stalled)
//  rst is synchronous: bus idle, phase_ticks 10, restart_gap_ticks 50
//  config writes are always ready and expected only while the bus is idle
// ----------------------------------------------------------------------------
module i2c_register_master_core import i2crm_pkg::*; #(
  parameter int unsigned RECOVERY_PULSES = 9
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tick_valid,
  output logic                   tick_stall,
  input  tick_item_t             tick_item,
  output logic                   res_valid,
  input  logic                   res_stall,
  output res_item_t              res_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [9:0]  phase_ticks;
  logic [11:0] restart_gap_ticks;
  logic        accept;
  logic        main_free;
  logic        skid_valid;
  res_item_t   skid_item;
  res_item_t   result;

  assign cfg_ready  = 1'b1;
  assign tick_stall = skid_valid;
  assign accept     = tick_valid && !skid_valid;
  assign main_free  = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks       <= PHASE_TICKS_RST;
      restart_gap_ticks <= RESTART_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PHASE_TICKS: phase_ticks       <= cfg_data[9:0];
        CFG_RESTART_GAP: restart_gap_ticks <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  i2crm_seq #(
    .RECOVERY_PULSES(RECOVERY_PULSES)
  ) u_seq (
    .clk               (clk),
    .rst               (rst),
    .step              (accept),
    .tick_item         (tick_item),
    .phase_ticks       (phase_ticks),
    .restart_gap_ticks (restart_gap_ticks),
    .result            (result)
  );

  // result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (main_free) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (main_free) begin
      res_valid <= accept;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (main_free) begin
        res_item <= skid_item;
      end
    end else if (main_free) begin
      if (accept) begin
        res_item <= result;
      end
    end else if (accept) begin
      skid_item <= result;
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for i2c_register_master_core. A bus sequencer model
// predicts the pin drives and read data of every tick item. Directed commands
// run over several timing settings, with random gaps on the tick side and
// random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
  import i2crm_pkg::*;

  localparam int unsigned RECOVERY_PULSES = 9;
  localparam int unsigned CYCLE_LIMIT     = 2_000_000;
  localparam int unsigned MAX_REPORTS     = 50;

  // reserved command codes, handled as tick only
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  // byte being sent on the bus
  localparam logic [1:0] TX_ADDR   = 2'd0;
  localparam logic [1:0] TX_REG    = 2'd1;
  localparam logic [1:0] TX_DATA   = 2'd2;
  localparam logic [1:0] TX_RDADDR = 2'd3;

  // sda level fed back by the slave side
  localparam int unsigned SDA_LOW  = 0;
  localparam int unsigned SDA_HIGH = 1;
  localparam int unsigned SDA_RAND = 2;

  typedef enum logic [3:0] {
    S_IDLE, S_REC_HIGH, S_REC_LOW, S_START_IDLE, S_START_HOLD, S_TX_LOW, S_TX_HIGH,
    S_GAP, S_RX_LOW, S_RX_HIGH, S_ACK_LOW, S_ACK_HIGH, S_STOP_LOW, S_STOP_HIGH,
    S_STOP_DONE
  } bus_phase_t;

  typedef struct packed {
    bus_phase_t  phase;
    logic [2:0]  cmd;
    logic [11:0] tcnt;
    logic [3:0]  bits;
    logic [7:0]  shreg;
    logic [7:0]  left;
    logic [7:0]  lowb;
    logic [6:0]  dev;
    logic [7:0]  regb;
    logic [7:0]  wdata;
    logic [1:0]  stage;
  } bus_state_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   tick_valid = 1'b0;
  logic                   tick_stall;
  tick_item_t             tick_item = '0;
  logic                   res_valid;
  logic                   res_stall = 1'b0;
  res_item_t              res_item;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_PHASE_TICKS;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  tick_item_t  tick_q[$];
  res_item_t   pin_res_q[$];
  bus_state_t  bus_st = '0;
  bus_state_t  st_work;
  res_item_t   res_want;
  res_item_t   res_got;
  logic [9:0]  cfg_ph = PHASE_TICKS_RST;
  logic [11:0] cfg_gap = RESTART_GAP_RST;

  int unsigned cyc_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_at = 200;
  bit          idle_on = 1'b1;
  int unsigned sda_mode = SDA_RAND;

  i2c_register_master_core #(
    .RECOVERY_PULSES(RECOVERY_PULSES)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .tick_valid(tick_valid),
    .tick_stall(tick_stall),
    .tick_item (tick_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // one tick of the bus sequencer: pin drives from the phase at tick start
  function automatic res_item_t bus_step(inout bus_state_t s, input tick_item_t t,
                                         input logic [9:0] ph, input logic [11:0] gap);
    res_item_t   r;
    bus_phase_t  nxt;
    int unsigned len;
    logic        ack;
    r = '0;
    if (s.phase == S_IDLE && t.cmd >= CMD_RECOVER && t.cmd <= CMD_BURST) begin
      s.cmd   = t.cmd;
      s.dev   = t.dev_addr;
      s.regb  = t.reg_addr;
      s.wdata = t.write_data;
      s.stage = TX_ADDR;
      s.lowb  = '0;
      s.tcnt  = '0;
      case (t.cmd)
        CMD_READ8:  s.left = 8'd1;
        CMD_READ16: s.left = 8'd2;
        default:    s.left = t.burst_len;
      endcase
      if (t.cmd == CMD_RECOVER) begin
        s.bits  = 4'(RECOVERY_PULSES - 1);
        s.phase = S_REC_HIGH;
      end else begin
        s.phase = S_START_IDLE;
      end
    end

    ack = (s.left > 8'd1);
    r.busy_res = (s.phase != S_IDLE);
    case (s.phase)
      S_REC_LOW, S_GAP, S_RX_LOW: r.scl_drive_low = 1'b1;
      S_START_HOLD, S_STOP_HIGH:  r.sda_drive_low = 1'b1;
      S_STOP_LOW: begin
        r.scl_drive_low = 1'b1;
        r.sda_drive_low = 1'b1;
      end
      S_TX_LOW, S_TX_HIGH: begin
        r.scl_drive_low = (s.phase == S_TX_LOW);
        r.sda_drive_low = (s.bits < 4'd8) && !s.shreg[7];
      end
      S_ACK_LOW: begin
        r.scl_drive_low = 1'b1;
        r.sda_drive_low = ack;
      end
      S_ACK_HIGH: r.sda_drive_low = ack;
      default: ;
    endcase

    if (s.phase != S_IDLE) begin
      len = (s.phase == S_GAP) ? gap : ((ph == 10'd0) ? 1 : ph);
      if (s.tcnt + 1 < len) begin
        s.tcnt = s.tcnt + 12'd1;
      end else begin
        s.tcnt = '0;
        nxt = S_IDLE;
        case (s.phase)
          S_REC_HIGH: nxt = S_REC_LOW;
          S_REC_LOW: begin
            if (s.bits == 4'd0) begin
              nxt = S_STOP_LOW;
            end else begin
              s.bits = s.bits - 4'd1;
              nxt = S_REC_HIGH;
            end
          end
          S_START_IDLE: nxt = S_START_HOLD;
          S_START_HOLD: begin
            s.shreg = {s.dev, s.stage == TX_RDADDR};
            s.bits  = '0;
            nxt     = S_TX_LOW;
          end
          S_TX_LOW: nxt = S_TX_HIGH;
          S_TX_HIGH: begin
            if (s.bits < 4'd8) s.shreg = {s.shreg[6:0], 1'b0};
            s.bits = s.bits + 4'd1;
            if (s.bits < 4'd9) begin
              nxt = S_TX_LOW;
            end else if (s.stage == TX_ADDR) begin
              s.stage = TX_REG;
              s.shreg = s.regb;
              s.bits  = '0;
              nxt     = S_TX_LOW;
            end else if (s.stage == TX_REG) begin
              if (s.cmd == CMD_WRITE) begin
                s.stage = TX_DATA;
                s.shreg = s.wdata;
                s.bits  = '0;
                nxt     = S_TX_LOW;
              end else begin
                s.stage = TX_RDADDR;
                nxt     = S_GAP;
              end
            end else if (s.stage == TX_RDADDR && s.left != 8'd0) begin
              s.bits  = '0;
              s.shreg = '0;
              nxt     = S_RX_LOW;
            end else begin
              nxt = S_STOP_LOW;
            end
          end
          S_GAP:    nxt = S_START_IDLE;
          S_RX_LOW: nxt = S_RX_HIGH;
          S_RX_HIGH: begin
            s.shreg = {s.shreg[6:0], t.sda_in};
            s.bits  = s.bits + 4'd1;
            nxt     = (s.bits >= 4'd8) ? S_ACK_LOW : S_RX_LOW;
          end
          S_ACK_LOW: nxt = S_ACK_HIGH;
          S_ACK_HIGH: begin
            // first byte of a 16-bit read is held back as the low half
            if (s.cmd == CMD_READ16 && s.left > 8'd1) begin
              s.lowb = s.shreg;
            end else begin
              r.read_valid = 1'b1;
              r.last_read  = (s.left <= 8'd1);
              r.read_value = (s.cmd == CMD_READ16) ? {s.shreg, s.lowb} : {8'h00, s.shreg};
            end
            if (s.left != 8'd0) s.left = s.left - 8'd1;
            if (s.left == 8'd0) begin
              nxt = S_STOP_LOW;
            end else begin
              s.bits  = '0;
              s.shreg = '0;
              nxt     = S_RX_LOW;
            end
          end
          S_STOP_LOW:  nxt = S_STOP_HIGH;
          S_STOP_HIGH: nxt = S_STOP_DONE;
          default:     nxt = S_IDLE;
        endcase
        // a zero restart gap skips straight to the repeated start
        s.phase = (nxt == S_GAP && gap == 12'd0) ? S_START_IDLE : nxt;
      end
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic tick_item_t cmd_tick(input logic [2:0] c, input logic [6:0] dev_a,
                                          input logic [7:0] reg_a, input logic [7:0] wr_d,
                                          input logic [7:0] blen);
    tick_item_t t;
    t.cmd        = c;
    t.dev_addr   = dev_a;
    t.reg_addr   = reg_a;
    t.write_data = wr_d;
    t.burst_len  = blen;
    case (sda_mode)
      SDA_LOW:  t.sda_in = 1'b0;
      SDA_HIGH: t.sda_in = 1'b1;
      default:  t.sda_in = 1'($urandom_range(0, 1));
    endcase
    return t;
  endfunction

  function automatic tick_item_t rand_tick(input logic [2:0] c);
    return cmd_tick(c, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  task automatic chk_field(input string fname, input logic [15:0] want,
                           input logic [15:0] got);
    if (got !== want) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
    end
  endtask

  // tick driver
  always @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
      gap_left   <= 0;
    end else if (!tick_valid || !tick_stall) begin
      if (gap_left != 0) begin
        tick_valid <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (tick_q.size() != 0) begin
        tick_item  <= tick_q.pop_front();
        tick_valid <= 1'b1;
        gap_left   <= pick_gap();
      end else begin
        tick_valid <= 1'b0;
      end
    end
  end

  // result side stalls, with a long hold-off while ticks are offered
  always @(posedge clk) begin
    if (rst) begin
      res_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      res_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (cyc_cnt >= hold_at && tick_valid) begin
      res_stall  <= 1'b1;
      stall_left <= 60;
      hold_at    <= cyc_cnt + 700;
    end else if (idle_on) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          res_stall  <= 1'b1;
          stall_left <= $urandom_range(0, 2);
        end
        4: begin
          res_stall  <= 1'b1;
          stall_left <= $urandom_range(5, 40);
        end
        default: res_stall <= 1'b0;
      endcase
    end else begin
      res_stall <= 1'b0;
    end
  end

  // monitor: predicts on every accepted tick, checks every accepted result
  always @(posedge clk) begin
    if (rst) begin
      bus_st  <= '0;
      cfg_ph  <= PHASE_TICKS_RST;
      cfg_gap <= RESTART_GAP_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PHASE_TICKS) cfg_ph <= cfg_data[9:0];
        else cfg_gap <= cfg_data;
      end
      if (tick_valid && !tick_stall) begin
        st_work = bus_st;
        res_want = bus_step(st_work, tick_item, cfg_ph, cfg_gap);
        pin_res_q.push_back(res_want);
        bus_st <= st_work;
      end
      if (res_valid && !res_stall) begin
        if (pin_res_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: result with none pending, expected nothing, actual %h",
                     $time, res_item);
        end else begin
          res_got = pin_res_q.pop_front();
          chk_field("scl_drive_low", 16'(res_got.scl_drive_low),
                    16'(res_item.scl_drive_low));
          chk_field("sda_drive_low", 16'(res_got.sda_drive_low),
                    16'(res_item.sda_drive_low));
          chk_field("busy_res", 16'(res_got.busy_res), 16'(res_item.busy_res));
          chk_field("read_valid", 16'(res_got.read_valid), 16'(res_item.read_valid));
          chk_field("read_value", res_got.read_value, res_item.read_value);
          chk_field("last_read", 16'(res_got.last_read), 16'(res_item.last_read));
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic put_tick(input tick_item_t t);
    @(negedge clk);
    while (tick_q.size() >= 4) @(negedge clk);
    tick_q.push_back(t);
  endtask

  // keep ticks flowing until the sequencer is back in idle
  task automatic wait_bus_idle();
    forever begin
      @(negedge clk);
      if (tick_q.size() == 0 && !tick_valid && bus_st.phase == S_IDLE) break;
      if (bus_st.phase != S_IDLE && tick_q.size() < 3)
        tick_q.push_back(rand_tick(($urandom_range(0, 7) == 0) ? CMD_RSVD6 : CMD_TICK));
    end
  endtask

  task automatic run_cmd(input tick_item_t t);
    put_tick(t);
    wait_bus_idle();
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pin_res_q.size() != 0 || tick_q.size() != 0 || tick_valid) @(negedge clk);
  endtask

  task automatic set_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // short phases with the reset restart gap, then zero phase and no gap
    set_cfg(CFG_PHASE_TICKS, 12'd1);
    run_cmd(cmd_tick(CMD_READ16, 7'h55, 8'hA3, 8'h5A, 8'hC3));
    set_cfg(CFG_PHASE_TICKS, 12'd0);
    set_cfg(CFG_RESTART_GAP, 12'd0);
    sda_mode = SDA_HIGH;
    run_cmd(cmd_tick(CMD_READ8, 7'h7F, 8'hFF, 8'hFF, 8'hFF));
    set_cfg(CFG_RESTART_GAP, 12'd2);
    sda_mode = SDA_LOW;
    run_cmd(cmd_tick(CMD_WRITE, 7'h00, 8'h00, 8'h00, 8'h00));
    sda_mode = SDA_RAND;
    run_cmd(rand_tick(CMD_RECOVER));
    run_cmd(cmd_tick(CMD_BURST, 7'h2A, 8'h10, 8'h00, 8'd0));

    // back to back ticks with no random result stalls
    idle_on = 1'b0;
    run_cmd(cmd_tick(CMD_BURST, 7'h6B, 8'hE7, 8'h00, 8'd2));
    idle_on = 1'b1;

    put_tick(rand_tick(CMD_RSVD6));
    put_tick(rand_tick(CMD_RSVD7));
    put_tick(rand_tick(CMD_TICK));
    put_tick(rand_tick(CMD_READ8));
    // new commands arriving while one is running are dropped
    put_tick(rand_tick(CMD_WRITE));
    put_tick(rand_tick(CMD_BURST));
    wait_bus_idle();

    // upper data bits lie outside the phase register
    set_cfg(CFG_PHASE_TICKS, 12'hC03);
    set_cfg(CFG_RESTART_GAP, 12'd1);
    run_cmd(rand_tick(CMD_RECOVER));

    wait_drained();
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
